>>> rtl/core/rtt_pkg.sv
// Package for the running transaction table: field widths, command and status
// codes, the stored entry type and the default table depth. No dependencies.
package rtt_pkg;

  localparam int RTT_DEPTH = 1024;
  localparam int TS_W      = 64;
  localparam int COUNT_W   = 10;

  typedef enum logic [1:0] {
    CMD_REG   = 2'd0,
    CMD_END   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [TS_W-1:0] id;
    logic [TS_W-1:0] snap;
  } entry_t;

endpackage

>>> rtl/core/rtt_if.sv
// Valid/ready channel interfaces for the running transaction table.
// Depends on rtt_pkg for field widths.
interface rtt_in_if;
  import rtt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [TS_W-1:0]    now_timestamp;
  logic               commit_min_valid;
  logic [TS_W-1:0]    commit_min;
  logic [TS_W-1:0]    end_id;

  modport source (output valid, command, now_timestamp, commit_min_valid, commit_min,
                  end_id, input ready);
  modport sink   (input valid, command, now_timestamp, commit_min_valid, commit_min,
                  end_id, output ready);
endinterface

interface rtt_out_if;
  import rtt_pkg::*;
  logic               valid;
  logic               ready;
  logic [TS_W-1:0]    assigned_id;
  logic [TS_W-1:0]    assigned_snapshot;
  logic [TS_W-1:0]    oldest_snapshot;
  logic [COUNT_W-1:0] running_count;
  logic [COUNT_W-1:0] peak_count;
  logic [1:0]         status;

  modport source (output valid, assigned_id, assigned_snapshot, oldest_snapshot,
                  running_count, peak_count, status, input ready);
  modport sink   (input valid, assigned_id, assigned_snapshot, oldest_snapshot,
                  running_count, peak_count, status, output ready);
endinterface

>>> rtl/core/running_transaction_table.sv
// Running transaction table. Entries (id, snapshot) sit in a ring in one
// synchronous memory, oldest at the head. A register or a query makes its
// memory access (tail write plus head read) when taken, then returns the
// result once the result register is free. An end command searches from the
// head, one entry read per cycle, then closes the gap by moving older entries
// up one slot per cycle through the single read and write port. One command
// is handled at a time; the result register lets the next command enter while
// a result waits.
// Depends on rtt_pkg, rtt_if and rtt_store.
module running_transaction_table #(
  parameter int DEPTH = rtt_pkg::RTT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  rtt_in_if.sink    in_txn,
  rtt_out_if.source out_txn
);
  import rtt_pkg::*;

  localparam int AW = $clog2(DEPTH);

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH-1) : p - AW'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     peak_r, peak_nxt;

  logic [TS_W-1:0]   now_r, now_nxt;
  logic [TS_W-1:0]   end_id_r, end_id_nxt;
  logic [TS_W-1:0]   a_id_r, a_id_nxt;
  logic [TS_W-1:0]   a_snap_r, a_snap_nxt;
  status_t           sts_r, sts_nxt;

  // search and shift bookkeeping
  logic [AW-1:0]     rd_pos_r, rd_pos_nxt;
  logic [AW-1:0]     iss_r, iss_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]     cmp_pos_r, cmp_pos_nxt;
  logic [AW-1:0]     sh_pos_r, sh_pos_nxt;
  logic              wr_vld_r, wr_vld_nxt;
  logic [AW-1:0]     wr_pos_r, wr_pos_nxt;

  // read-during-write bypass for the head read
  logic              fwd_vld_r;
  logic [TS_W-1:0]   fwd_snap_r;

  logic              out_vld_r, out_vld_nxt;
  logic [TS_W-1:0]   o_id_r, o_id_nxt;
  logic [TS_W-1:0]   o_snap_r, o_snap_nxt;
  logic [TS_W-1:0]   o_old_r, o_old_nxt;
  logic [AW-1:0]     o_cnt_r, o_cnt_nxt;
  logic [AW-1:0]     o_peak_r, o_peak_nxt;
  status_t           o_sts_r, o_sts_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;

  logic              in_ready;
  logic              id_match;
  logic [TS_W-1:0]   head_snap;

  rtt_store #(.DEPTH(DEPTH)) u_store (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_entry (mem_wdata),
    .rd_en    (mem_re),
    .rd_addr  (mem_raddr),
    .rd_entry (mem_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign id_match  = cmp_vld_r && (mem_rdata.id == end_id_r);
  assign head_snap = fwd_vld_r ? fwd_snap_r : mem_rdata.snap;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    peak_nxt    = peak_r;
    now_nxt     = now_r;
    end_id_nxt  = end_id_r;
    a_id_nxt    = a_id_r;
    a_snap_nxt  = a_snap_r;
    sts_nxt     = sts_r;
    rd_pos_nxt  = rd_pos_r;
    iss_nxt     = iss_r;
    cmp_vld_nxt = 1'b0;
    cmp_pos_nxt = cmp_pos_r;
    sh_pos_nxt  = sh_pos_r;
    wr_vld_nxt  = 1'b0;
    wr_pos_nxt  = wr_pos_r;
    out_vld_nxt = out_vld_r && !out_txn.ready;
    o_id_nxt    = o_id_r;
    o_snap_nxt  = o_snap_r;
    o_old_nxt   = o_old_r;
    o_cnt_nxt   = o_cnt_r;
    o_peak_nxt  = o_peak_r;
    o_sts_nxt   = o_sts_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_pos_r;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_txn.valid) begin
          now_nxt    = in_txn.now_timestamp;
          end_id_nxt = in_txn.end_id;
          a_id_nxt   = '0;
          a_snap_nxt = '0;
          sts_nxt    = STS_OK;
          mem_re     = 1'b1;
          mem_raddr  = head_r;
          state_nxt  = ST_FIN;
          unique case (cmd_e_t'(in_txn.command))
            CMD_REG: begin
              if (cnt_r == AW'(DEPTH-1)) begin
                sts_nxt = STS_FULL;
              end else begin
                a_id_nxt       = in_txn.now_timestamp;
                a_snap_nxt     = in_txn.commit_min_valid ? in_txn.commit_min
                                                         : in_txn.now_timestamp;
                mem_we         = 1'b1;
                mem_waddr      = ring_add(head_r, cnt_r);
                mem_wdata.id   = a_id_nxt;
                mem_wdata.snap = a_snap_nxt;
                cnt_nxt        = cnt_r + AW'(1);
                if (cnt_nxt > peak_r) begin
                  peak_nxt = cnt_nxt;
                end
              end
            end
            CMD_END: begin
              if (cnt_r == '0) begin
                sts_nxt = STS_NOT_FOUND;
              end else begin
                mem_re     = 1'b0;
                rd_pos_nxt = head_r;
                iss_nxt    = '0;
                state_nxt  = ST_SEARCH;
              end
            end
            default: begin
              // query, and the unused code, only report
            end
          endcase
        end
      end

      ST_SEARCH: begin
        priority if (id_match) begin
          sh_pos_nxt = cmp_pos_r;
          state_nxt  = ST_SHIFT;
        end else if (iss_r == cnt_r) begin
          sts_nxt   = STS_NOT_FOUND;
          mem_re    = 1'b1;
          mem_raddr = head_r;
          state_nxt = ST_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = rd_pos_r;
          cmp_vld_nxt = 1'b1;
          cmp_pos_nxt = rd_pos_r;
          rd_pos_nxt  = ring_next(rd_pos_r);
          iss_nxt     = iss_r + AW'(1);
        end
      end

      ST_SHIFT: begin
        // read slot p-1 now, write it into slot p next cycle
        mem_we    = wr_vld_r;
        mem_waddr = wr_pos_r;
        mem_wdata = mem_rdata;
        if (sh_pos_r != head_r) begin
          mem_re     = 1'b1;
          mem_raddr  = ring_prev(sh_pos_r);
          wr_vld_nxt = 1'b1;
          wr_pos_nxt = sh_pos_r;
          sh_pos_nxt = ring_prev(sh_pos_r);
        end else begin
          head_nxt  = ring_next(head_r);
          cnt_nxt   = cnt_r - AW'(1);
          mem_re    = 1'b1;
          mem_raddr = ring_next(head_r);
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_vld_r || out_txn.ready) begin
          out_vld_nxt = 1'b1;
          o_id_nxt    = a_id_r;
          o_snap_nxt  = a_snap_r;
          o_old_nxt   = (cnt_r == '0) ? now_r : head_snap;
          o_cnt_nxt   = cnt_r;
          o_peak_nxt  = peak_r;
          o_sts_nxt   = sts_r;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      cnt_r     <= '0;
      peak_r    <= '0;
      cmp_vld_r <= 1'b0;
      wr_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      peak_r    <= peak_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      wr_vld_r  <= wr_vld_nxt;
      if (mem_re) begin
        fwd_vld_r <= mem_we && (mem_waddr == mem_raddr);
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    end_id_r  <= end_id_nxt;
    a_id_r    <= a_id_nxt;
    a_snap_r  <= a_snap_nxt;
    sts_r     <= sts_nxt;
    rd_pos_r  <= rd_pos_nxt;
    iss_r     <= iss_nxt;
    cmp_pos_r <= cmp_pos_nxt;
    sh_pos_r  <= sh_pos_nxt;
    wr_pos_r  <= wr_pos_nxt;
    if (mem_re) begin
      fwd_snap_r <= mem_wdata.snap;
    end
    o_id_r    <= o_id_nxt;
    o_snap_r  <= o_snap_nxt;
    o_old_r   <= o_old_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_peak_r  <= o_peak_nxt;
    o_sts_r   <= o_sts_nxt;
  end

  assign in_txn.ready              = in_ready;
  assign out_txn.valid             = out_vld_r;
  assign out_txn.assigned_id       = o_id_r;
  assign out_txn.assigned_snapshot = o_snap_r;
  assign out_txn.oldest_snapshot   = o_old_r;
  assign out_txn.running_count     = COUNT_W'(o_cnt_r);
  assign out_txn.peak_count        = COUNT_W'(o_peak_r);
  assign out_txn.status            = o_sts_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= AW'(DEPTH-1))
    else $error("entry count above capacity");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= cnt_r)
    else $error("peak below running count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_txn.valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while one is in progress");

  a_shift_no_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && mem_we && mem_re && sh_pos_r != head_r) |->
      (mem_waddr != mem_raddr))
    else $error("shift read collides with pending write");

endmodule

>>> rtl/core/rtt_store.sv
// Entry store of the running transaction table: one write port, one read port,
// registered read data. Depends on rtt_pkg for the entry type.
module rtt_store #(
  parameter int DEPTH = rtt_pkg::RTT_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rtt_pkg::entry_t          wr_entry,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rtt_pkg::entry_t          rd_entry
);
  import rtt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

>>> tb/running_transaction_table_test.sv
`timescale 1ns / 100ps
// Self-checking test for running_transaction_table: directed rows, a fill past
// the full mark, then random traffic under idling and back-pressure phases.
// Depends on rtt_pkg, rtt_in_if/rtt_out_if and the table RTL.
module running_transaction_table_test;
  import rtt_pkg::*;

  localparam int TABLE_DEPTH      = RTT_DEPTH;
  localparam int RUN_LIMIT        = 2_000_000;
  localparam int DRAIN_LIMIT      = 200_000;
  localparam int RANDOM_PER_PHASE = 30;
  localparam logic [1:0] CMD_SPARE = 2'd3;  // not decoded, behaves as a query
  localparam logic [TS_W-1:0] TS_MAX = '1;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [TS_W-1:0] now_ts;
    logic            commit_valid;
    logic [TS_W-1:0] commit_ts;
    logic [TS_W-1:0] end_id;
  } txn_t;

  typedef struct packed {
    logic [TS_W-1:0]    assigned_id;
    logic [TS_W-1:0]    assigned_snapshot;
    logic [TS_W-1:0]    oldest_snapshot;
    logic [COUNT_W-1:0] running_count;
    logic [COUNT_W-1:0] peak_count;
    status_t            status;
  } reply_t;

  typedef struct packed {
    txn_t   stim;
    bit     known;
    reply_t reply;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rtt_in_if  in_txn();
  rtt_out_if out_txn();

  running_transaction_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_txn(in_txn),
    .out_txn(out_txn)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table
  logic [TS_W-1:0] ring_ids   [TABLE_DEPTH];
  logic [TS_W-1:0] ring_snaps [TABLE_DEPTH];
  int ring_head;
  int live_count;
  int peak_live;
  logic [TS_W-1:0] wall_clock;

  reply_t replies_due [$];

  int cycle_count     = 0;
  int stall_until     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int mismatch_count  = 0;
  int items_sent      = 0;
  int replies_checked = 0;
  int full_hits       = 0;
  int unknown_ends    = 0;

  // Rows with known = 1 carry a hand-written reply; the rest use the predictor.
  dir_row_t directed_rows [20] = '{
    '{'{CMD_QUERY, 64'd0, 1'b0, 64'd0, 64'd0}, 1'b1,
      '{64'd0, 64'd0, 64'd0, 10'd0, 10'd0, STS_OK}},
    '{'{CMD_END, TS_MAX, 1'b0, 64'd0, 64'd5}, 1'b1,
      '{64'd0, 64'd0, TS_MAX, 10'd0, 10'd0, STS_NOT_FOUND}},
    '{'{CMD_SPARE, 64'h1234, 1'b1, TS_MAX, TS_MAX}, 1'b1,
      '{64'd0, 64'd0, 64'h1234, 10'd0, 10'd0, STS_OK}},
    '{'{CMD_REG, TS_MAX, 1'b0, 64'hdead, 64'd0}, 1'b1,
      '{TS_MAX, TS_MAX, TS_MAX, 10'd1, 10'd1, STS_OK}},
    '{'{CMD_REG, 64'd0, 1'b1, 64'd0, TS_MAX}, 1'b1,
      '{64'd0, 64'd0, TS_MAX, 10'd2, 10'd2, STS_OK}},
    '{'{CMD_REG, 64'd100, 1'b1, 64'h8000_0000_0000_0000, 64'd0}, 1'b1,
      '{64'd100, 64'h8000_0000_0000_0000, TS_MAX, 10'd3, 10'd3, STS_OK}},
    '{'{CMD_REG, 64'd100, 1'b0, TS_MAX, 64'd0}, 1'b0, '0},
    '{'{CMD_REG, 64'd200, 1'b1, TS_MAX, 64'd0}, 1'b0, '0},
    '{'{CMD_END, 64'd250, 1'b0, 64'd0, 64'd100}, 1'b0, '0},  // older duplicate goes
    '{'{CMD_QUERY, 64'd300, 1'b0, 64'd0, 64'd0}, 1'b0, '0},
    '{'{CMD_END, 64'd310, 1'b0, 64'd0, 64'd100}, 1'b0, '0},
    '{'{CMD_END, 64'd320, 1'b0, 64'd0, 64'd100}, 1'b1,
      '{64'd0, 64'd0, TS_MAX, 10'd3, 10'd5, STS_NOT_FOUND}},
    '{'{CMD_END, 64'd330, 1'b0, 64'd0, 64'd200}, 1'b0, '0},  // youngest
    '{'{CMD_END, 64'd340, 1'b0, 64'd0, TS_MAX}, 1'b0, '0},   // head
    '{'{CMD_END, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 64'd0}, 1'b0, '0},
    '{'{CMD_END, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'd0, 64'd0}, 1'b1,
      '{64'd0, 64'd0, 64'haaaa_aaaa_aaaa_aaaa, 10'd0, 10'd5, STS_NOT_FOUND}},
    '{'{CMD_QUERY, TS_MAX, 1'b1, TS_MAX, TS_MAX}, 1'b1,
      '{64'd0, 64'd0, TS_MAX, 10'd0, 10'd5, STS_OK}},
    '{'{CMD_REG, 64'h0123_4567_89ab_cdef, 1'b1, 64'hfedc_ba98_7654_3210, 64'd0}, 1'b0, '0},
    '{'{CMD_SPARE, 64'd400, 1'b0, 64'd0, 64'd0}, 1'b0, '0},
    '{'{CMD_END, 64'd410, 1'b0, 64'd0, 64'h0123_4567_89ab_cdef}, 1'b0, '0}
  };

  function automatic reply_t predict_reply(input txn_t t);
    reply_t r;
    int hit;
    int pos;
    int prev;
    r = '0;
    r.status = STS_OK;
    hit = -1;
    case (t.command)
      CMD_REG: begin
        if (live_count >= TABLE_DEPTH - 1) begin
          r.status = STS_FULL;
          full_hits++;
        end else begin
          pos = (ring_head + live_count) % TABLE_DEPTH;
          r.assigned_id = t.now_ts;
          r.assigned_snapshot = t.commit_valid ? t.commit_ts : t.now_ts;
          ring_ids[pos] = r.assigned_id;
          ring_snaps[pos] = r.assigned_snapshot;
          live_count++;
          if (live_count > peak_live) peak_live = live_count;
        end
      end
      CMD_END: begin
        for (int i = 0; i < live_count && hit < 0; i++) begin
          if (ring_ids[(ring_head + i) % TABLE_DEPTH] == t.end_id)
            hit = (ring_head + i) % TABLE_DEPTH;
        end
        if (hit < 0) begin
          r.status = STS_NOT_FOUND;
          unknown_ends++;
        end else begin
          // close the gap by moving older entries one slot toward the tail
          pos = hit;
          while (pos != ring_head) begin
            prev = (pos == 0) ? TABLE_DEPTH - 1 : pos - 1;
            ring_ids[pos] = ring_ids[prev];
            ring_snaps[pos] = ring_snaps[prev];
            pos = prev;
          end
          ring_ids[ring_head] = '0;
          ring_snaps[ring_head] = '0;
          ring_head = (ring_head + 1) % TABLE_DEPTH;
          live_count--;
        end
      end
      default: ;
    endcase
    r.oldest_snapshot = (live_count == 0) ? t.now_ts : ring_snaps[ring_head];
    r.running_count = COUNT_W'(live_count);
    r.peak_count = COUNT_W'(peak_live);
    return r;
  endfunction

  // Mostly ends of live ids near the head, some unknown ids, clock with repeats.
  function automatic txn_t random_txn();
    txn_t t;
    int roll;
    int reg_w;
    int end_w;
    int offset;
    if (live_count == 0) begin
      reg_w = 55;
      end_w = 20;
    end else if (live_count >= 40) begin
      reg_w = 20;
      end_w = 55;
    end else begin
      reg_w = 40;
      end_w = 35;
    end
    roll = $urandom_range(99);
    if (roll < reg_w) t.command = CMD_REG;
    else if (roll < reg_w + end_w) t.command = CMD_END;
    else if (roll < 95) t.command = CMD_QUERY;
    else t.command = CMD_SPARE;
    if ($urandom_range(19) == 0) wall_clock = {$urandom, $urandom};
    else wall_clock = wall_clock + $urandom_range(3);
    t.now_ts = wall_clock;
    t.commit_valid = $urandom_range(1);
    t.commit_ts = $urandom_range(1) ? {$urandom, $urandom} : wall_clock - $urandom_range(50);
    if (live_count > 0 && $urandom_range(9) < 8) begin
      offset = ($urandom_range(3) == 0) ? $urandom_range(live_count - 1)
                                        : $urandom_range(live_count < 4 ? live_count - 1 : 3);
      t.end_id = ring_ids[(ring_head + offset) % TABLE_DEPTH];
    end else begin
      t.end_id = $urandom_range(1) ? {$urandom, $urandom} : wall_clock + 64'd1;
    end
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 100)
      $display("[cycle %0d] %s: got %h, want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 84;
        recv_idle_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_idle_pct = 84;
      end
      default: begin
        send_idle_pct = 8;
        recv_idle_pct = 8;
      end
    endcase
  endtask

  task automatic send_txn(input txn_t t, input bit typed_known = 1'b0,
                          input reply_t typed = '0);
    int gap;
    reply_t predicted;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_txn.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_txn.valid            <= 1'b1;
    in_txn.command          <= t.command;
    in_txn.now_timestamp    <= t.now_ts;
    in_txn.commit_min_valid <= t.commit_valid;
    in_txn.commit_min       <= t.commit_ts;
    in_txn.end_id           <= t.end_id;
    @(posedge clk);
    while (!in_txn.ready) @(posedge clk);
    predicted = predict_reply(t);
    replies_due.push_back(typed_known ? typed : predicted);
    items_sent++;
  endtask

  // Lowers valid and waits for a clock edge first, so valid is never lowered and raised in one step.
  task automatic wait_for_replies(input int max_cycles);
    int waited;
    waited = 0;
    in_txn.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    out_txn.ready <= (cycle_count >= stall_until) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_txn.valid && out_txn.ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with none due", out_txn.assigned_id, 64'd0);
      end else begin
        want = replies_due.pop_front();
        replies_checked++;
        if (out_txn.assigned_id !== want.assigned_id)
          report_mismatch("assigned_id", out_txn.assigned_id, want.assigned_id);
        if (out_txn.assigned_snapshot !== want.assigned_snapshot)
          report_mismatch("assigned_snapshot", out_txn.assigned_snapshot,
                          want.assigned_snapshot);
        if (out_txn.oldest_snapshot !== want.oldest_snapshot)
          report_mismatch("oldest_snapshot", out_txn.oldest_snapshot, want.oldest_snapshot);
        if (out_txn.running_count !== want.running_count)
          report_mismatch("running_count", 64'(out_txn.running_count),
                          64'(want.running_count));
        if (out_txn.peak_count !== want.peak_count)
          report_mismatch("peak_count", 64'(out_txn.peak_count), 64'(want.peak_count));
        if (out_txn.status !== want.status)
          report_mismatch("status", 64'(out_txn.status), 64'(want.status));
      end
    end
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    txn_t t;
    in_txn.valid            <= 1'b0;
    in_txn.command          <= CMD_QUERY;
    in_txn.now_timestamp    <= '0;
    in_txn.commit_min_valid <= 1'b0;
    in_txn.commit_min       <= '0;
    in_txn.end_id           <= '0;
    rst_n                   <= 1'b0;
    ring_head = 0;
    live_count = 0;
    peak_live = 0;
    wall_clock = 64'd1000;
    set_idling(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_txn(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].reply);
    wait_for_replies(DRAIN_LIMIT);

    // Fill to DEPTH-1 entries and push past it; the ring head is off slot 0,
    // so the tail wraps past the last slot.
    for (int n = 0; n < TABLE_DEPTH + 2; n++) begin
      t = random_txn();
      t.command = CMD_REG;
      send_txn(t);
    end
    t = random_txn();
    t.command = CMD_END;
    t.end_id = ~wall_clock;  // walks the whole full table
    send_txn(t);
    t = random_txn();
    t.command = CMD_END;
    t.end_id = ring_ids[(ring_head + live_count - 1) % TABLE_DEPTH];  // longest shift
    send_txn(t);
    for (int n = 0; n < 2; n++) begin
      t = random_txn();
      t.command = CMD_REG;
      send_txn(t);
    end
    wait_for_replies(DRAIN_LIMIT);

    // Random traffic starts on the full table left by the fill.
    for (int p = 0; p < 4; p++) begin
      set_idling(idle_mode_t'(p));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_txn(random_txn());
        if ($urandom_range(99) == 0) wait_for_replies(DRAIN_LIMIT);
      end
      wait_for_replies(DRAIN_LIMIT);
    end

    // Output held off while input keeps offering, so the block backs up.
    set_idling(IDLE_NONE);
    stall_until = cycle_count + 400;
    for (int n = 0; n < 20; n++) send_txn(random_txn());
    wait_for_replies(DRAIN_LIMIT);

    repeat (50) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch("replies never returned", 64'(replies_due.size()), 64'd0);

    $display("Sent %0d transactions, checked %0d replies: %0d full-table registers,",
             items_sent, replies_checked, full_hits);
    $display("%0d unmatched ends, peak of %0d entries, ring head ended at slot %0d",
             unknown_ends, peak_live, ring_head);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
